// ===== hdl/pcs_pkg.sv =====
`default_nettype none
package pcs_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 32;
   localparam int RGB_W   = 24;
   localparam int SLOT_W  = 3;
   localparam int TOL_W   = 8;

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [SLOT_W-1:0]  slot_type;

   typedef struct packed {
      logic                enabled;
      logic [PIXEL_W-1:0]  source;
      logic [RGB_W-1:0]    dest;
      logic [TOL_W-1:0]    tolerance;
   } entry_type;

endpackage
`default_nettype wire

// ===== hdl/pcs_match.sv =====
`default_nettype none
module pcs_match (
   input  pcs_pkg::entry_type entry,
   input  pcs_pkg::pixel_type pixel,
   output logic               hit
);
   import pcs_pkg::*;

   logic [3:0] chan_ok;
   logic       exact_ok;

   // one absolute-difference check per channel, alpha included
   always_comb begin
      logic [CHAN_W-1:0] a;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] d;
      for (int c = 0; c < 4; c++) begin
         a = pixel[c*CHAN_W +: CHAN_W];
         b = entry.source[c*CHAN_W +: CHAN_W];
         d = (a > b) ? (a - b) : (b - a);
         chan_ok[c] = (d <= entry.tolerance);
      end
   end

   // zero tolerance: exact RGB at opaque alpha, stored source alpha ignored
   assign exact_ok = (pixel == {ALPHA_OPAQUE, entry.source[RGB_W-1:0]});

   assign hit = entry.enabled &&
                ((entry.tolerance == '0) ? exact_ok : (&chan_ok));

endmodule
`default_nettype wire

// ===== hdl/pcs_table.sv =====
`default_nettype none
module pcs_table #(
   parameter int SWAP_ENTRIES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  pcs_pkg::slot_type  wr_slot,
   input  pcs_pkg::entry_type wr_entry,
   output pcs_pkg::entry_type entries [SWAP_ENTRIES]
);
   import pcs_pkg::*;

   for (genvar i = 0; i < SWAP_ENTRIES; i++) begin : g_slot
      entry_type entry_ff;
      logic      sel;

      // slots above the 3-bit slot range are never written
      assign sel = wr_en && (32'(wr_slot) == 32'(i));

      always_ff @(posedge clock) begin
         if (reset) begin
            entry_ff <= '0;
         end else if (sel) begin
            entry_ff <= wr_entry;
         end
      end

      assign entries[i] = entry_ff;
   end

endmodule
`default_nettype wire

// ===== hdl/pixel_color_swap_with_tolerance_top.sv =====
`default_nettype none
// Color-key swap with tolerance. A write request (kind = 1) loads one slot of
// the swap table the moment it is accepted and produces no response. A pixel
// request (kind = 0) is compared against every enabled entry in parallel; the
// lowest matching slot replaces the pixel with its destination RGB at alpha
// 0xFF, otherwise the pixel passes through. Throughput is one request per
// clock while req_stall is low. A pixel's response passes through the input
// register and the response register, with the compare logic between them.
// A write is held off only while a pixel waits in the input register behind
// a stalled response, so it never overtakes that pixel. The table comes out
// of reset with all entries disabled and all fields zero.
module pixel_color_swap_with_tolerance_top #(
   parameter int SWAP_ENTRIES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [pcs_pkg::PIXEL_W-1:0]       req_pixel_in,
   input  logic [pcs_pkg::SLOT_W-1:0]        req_entry_slot,
   input  logic [pcs_pkg::PIXEL_W-1:0]       req_entry_source,
   input  logic [pcs_pkg::RGB_W-1:0]         req_entry_dest,
   input  logic [pcs_pkg::TOL_W-1:0]         req_entry_tolerance,
   input  logic                              req_entry_enabled,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcs_pkg::PIXEL_W-1:0]       rsp_pixel_out,
   output logic                              rsp_matched,
   output logic [pcs_pkg::SLOT_W-1:0]        rsp_hit_slot
);
   import pcs_pkg::*;

   // ---------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------
   logic req_accept;
   logic rsp_free;     // response register can take a new value this edge
   logic s1_move;      // input stage hands its pixel on this edge

   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pixel_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pixel_ff;
   logic      rsp_matched_ff;
   slot_type  rsp_hit_slot_ff;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && rsp_free;
   // stall only when a pixel sits in the input stage and cannot leave
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // swap table: written straight from an accepted write request
   // ---------------------------------------------------------------
   entry_type wr_entry;
   entry_type entries [SWAP_ENTRIES];

   assign wr_entry.enabled   = req_entry_enabled;
   assign wr_entry.source    = req_entry_source;
   assign wr_entry.dest      = req_entry_dest;
   assign wr_entry.tolerance = req_entry_tolerance;

   pcs_table #(
      .SWAP_ENTRIES (SWAP_ENTRIES)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_accept && (req_kind == KIND_WRITE)),
      .wr_slot  (req_entry_slot),
      .wr_entry (wr_entry),
      .entries  (entries)
   );

   // ---------------------------------------------------------------
   // input stage
   // ---------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept && (req_kind == KIND_PIXEL)) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_kind == KIND_PIXEL)) begin
         s1_pixel_ff <= req_pixel_in;
      end
   end

   // ---------------------------------------------------------------
   // parallel compare, one lane per slot
   // ---------------------------------------------------------------
   logic [SWAP_ENTRIES-1:0] hit;
   logic [SWAP_ENTRIES-1:0] first_oh;

   for (genvar i = 0; i < SWAP_ENTRIES; i++) begin : g_lane
      pcs_match u_match (
         .entry (entries[i]),
         .pixel (s1_pixel_ff),
         .hit   (hit[i])
      );
   end

   // isolate the lowest set bit: lowest slot wins
   assign first_oh = hit & (~hit + {{(SWAP_ENTRIES-1){1'b0}}, 1'b1});

   logic [RGB_W-1:0] sel_dest;
   slot_type         sel_slot;

   always_comb begin
      sel_dest = '0;
      sel_slot = '0;
      for (int i = 0; i < SWAP_ENTRIES; i++) begin
         sel_dest = sel_dest | ({RGB_W{first_oh[i]}} & entries[i].dest);
         sel_slot = sel_slot | ({SLOT_W{first_oh[i]}} & SLOT_W'(i));
      end
   end

   // ---------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pixel_ff    <= (|hit) ? {ALPHA_OPAQUE, sel_dest} : s1_pixel_ff;
         rsp_matched_ff  <= |hit;
         rsp_hit_slot_ff <= sel_slot;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_matched   = rsp_matched_ff;
   assign rsp_hit_slot  = rsp_hit_slot_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_no_match_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_hit_slot == '0)
      else $error("hit slot nonzero without a match");

   a_match_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_pixel_out[PIXEL_W-1 -: CHAN_W] == ALPHA_OPAQUE)
      else $error("replaced pixel not opaque");

   a_pixel_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_free |=> rsp_valid)
      else $error("pixel left input stage without a response");

   a_write_behind_pixel: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_kind == KIND_WRITE) && s1_valid_ff |-> s1_move)
      else $error("write overtook a waiting pixel");

endmodule
`default_nettype wire
